// ===== sv/gcd_pkg.sv =====
// ----------------------------------------------------------------------------
// Great circle distance package
// Fixed-point constants, widths and the arctangent table shared by the
// angle conversion, CORDIC and square root logic.
// ----------------------------------------------------------------------------
package gcd_pkg;

    // Working width of the CORDIC datapath (Q2.30 angles, Q1.30 trig values).
    localparam int CW = 34;

    // Width used for half-unit angles while they are wrapped and folded.
    localparam int HW = 36;

    // Square root unit: radicand and root widths.
    localparam int SQ_RAD_W  = 62;
    localparam int SQ_ROOT_W = 31;

    // Angles in half-units of 1e-7 degree.
    localparam logic signed [HW-1:0] TURN_H    = 36'sd7200000000;
    localparam logic signed [HW-1:0] HALF_H    = 36'sd3600000000;
    localparam logic signed [HW-1:0] QUARTER_H = 36'sd1800000000;

    // Q30 constants.
    localparam logic [31:0] PI_Q30     = 32'd3373259426;
    localparam logic [31:0] HALFPI_Q30 = 32'd1686629713;
    localparam logic [31:0] ONE_Q30    = 32'd1073741824;
    localparam logic [31:0] GAIN_Q30   = 32'd652032874;

    // Divisor for the degree to radian conversion and its scaled reciprocal.
    localparam logic [31:0] DIV_H       = 32'd3600000000;
    localparam logic [63:0] RECIP_FULL  = (64'd1 << 32) * 64'd3373259426 / 64'd3600000000;
    localparam logic [31:0] RECIP_Q32   = RECIP_FULL[31:0];

    // Reset value of the sphere radius in metres.
    localparam logic [23:0] RADIUS_RESET = 24'd6371000;

    // Arctangent of 2^-i in Q30.
    function automatic logic [31:0] atan_q30(input int i);
        logic [31:0] r;
        case (i)
            0:       r = 32'd843314857;
            1:       r = 32'd497837829;
            2:       r = 32'd263043837;
            3:       r = 32'd133525159;
            4:       r = 32'd67021687;
            5:       r = 32'd33543516;
            6:       r = 32'd16775851;
            7:       r = 32'd8388437;
            8:       r = 32'd4194283;
            9:       r = 32'd2097149;
            10:      r = 32'd1048576;
            default: r = (i <= 30) ? (32'd1 << (30 - i)) : 32'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== sv/great_circle_distance.sv =====
// ----------------------------------------------------------------------------
// Great circle distance
// Haversine distance between two positions given in 1e-7 degree, in whole
// metres over a sphere whose radius is set through the configuration channel.
//
//   Channel   Handshake               Payload
//   input     start / busy            lat_a, lon_a, lat_b, lon_b
//   result    done (one-cycle strobe) distance_m
//   config    cfg_valid / cfg_ready   cfg_data (sphere radius in metres)
//
// A new position pair is taken in every cycle; busy stays low.
// Latency is set by the angle conversion, the two CORDIC pipelines, the
// two 31-stage square root pipelines and the registers between them.
// Reset clears all valid bits and loads the radius 6371000 m.
// The result side has no backpressure, so the pipeline never stalls.
// ----------------------------------------------------------------------------
module great_circle_distance #(
    parameter int CORDIC_ITERATIONS = 24
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic signed [30:0]  lat_a,
    input  logic signed [31:0]  lon_a,
    input  logic signed [30:0]  lat_b,
    input  logic signed [31:0]  lon_b,
    output logic                done,
    output logic [25:0]         distance_m,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [23:0]         cfg_data
);
    import gcd_pkg::*;

    localparam int LANES = 4;

    // Configuration register: a transfer is taken in every cycle.
    logic [23:0] radius_reg;

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            radius_reg <= cfg_data;
        end
    end

    // Half-unit angles of the four lanes: both latitudes, half their
    // difference and half the longitude difference.
    logic signed [HW-1:0] h_in [LANES];

    always_comb
    begin
        h_in[0] = $signed({{4{lat_a[30]}}, lat_a, 1'b0});
        h_in[1] = $signed({{4{lat_b[30]}}, lat_b, 1'b0});
        h_in[2] = $signed({{5{lat_b[30]}}, lat_b}) - $signed({{5{lat_a[30]}}, lat_a});
        h_in[3] = $signed({{4{lon_b[31]}}, lon_b}) - $signed({{4{lon_a[31]}}, lon_a});
    end

    // Valid bits of the angle conversion stages.
    logic [4:0] conv_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            conv_v_reg <= '0;
        end
        else
        begin
            conv_v_reg <= {conv_v_reg[3:0], start && !busy};
        end
    end

    logic signed [CW-1:0] lane_z    [LANES];
    logic                 lane_flip [LANES];
    logic signed [CW-1:0] rot_x     [LANES];
    logic signed [CW-1:0] rot_y     [LANES];
    logic [0:0]           rot_tag   [LANES];
    logic                 rot_valid;

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        logic signed [HW-1:0] hw;
        logic signed [HW-1:0] hf;
        logic                 fold;
        logic signed [HW-1:0] wrap_reg;
        logic [30:0]          mag_reg;
        logic                 neg2_reg;
        logic                 flip2_reg;
        logic [62:0]          pm_reg;
        logic [62:0]          pn3_reg;
        logic                 neg3_reg;
        logic                 flip3_reg;
        logic [30:0]          q0_reg;
        logic [62:0]          qd_reg;
        logic [62:0]          pn4_reg;
        logic                 neg4_reg;
        logic                 flip4_reg;
        logic [30:0]          q0_s;
        logic [62:0]          rem_s;
        logic [31:0]          q_s;
        logic signed [CW-1:0] z_reg;
        logic                 flip5_reg;

        // Wrap into (-half turn, half turn].
        always_comb
        begin
            if (h_in[l] > HALF_H)
            begin
                hw = h_in[l] - TURN_H;
            end
            else if (h_in[l] <= -HALF_H)
            begin
                hw = h_in[l] + TURN_H;
            end
            else
            begin
                hw = h_in[l];
            end
        end

        // Fold into +-quarter turn; the cosine changes sign when folded.
        always_comb
        begin
            fold = 1'b1;
            if (wrap_reg > QUARTER_H)
            begin
                hf = HALF_H - wrap_reg;
            end
            else if (wrap_reg < -QUARTER_H)
            begin
                hf = -HALF_H - wrap_reg;
            end
            else
            begin
                hf   = wrap_reg;
                fold = 1'b0;
            end
        end

        // Quotient estimate and the remainder correction.
        always_comb
        begin
            q0_s  = pm_reg[62:32];
            rem_s = pn4_reg - qd_reg;
            q_s   = {1'b0, q0_reg} + {31'd0, (rem_s >= {31'd0, DIV_H})};
        end

        always_ff @(posedge clk)
        begin
            // Wrap.
            wrap_reg  <= hw;
            // Fold and take the magnitude.
            mag_reg   <= hf[HW-1] ? 31'(-hf) : 31'(hf);
            neg2_reg  <= hf[HW-1];
            flip2_reg <= fold;
            // Scale by pi and by the reciprocal of the half turn.
            pm_reg    <= 63'(mag_reg * RECIP_Q32);
            pn3_reg   <= 63'(mag_reg * PI_Q30);
            neg3_reg  <= neg2_reg;
            flip3_reg <= flip2_reg;
            // Multiply back the quotient estimate.
            q0_reg    <= q0_s;
            qd_reg    <= 63'(q0_s * DIV_H);
            pn4_reg   <= pn3_reg;
            neg4_reg  <= neg3_reg;
            flip4_reg <= flip3_reg;
            // Corrected quotient with its sign, in Q2.30 radians.
            z_reg     <= neg4_reg ? -$signed({2'b00, q_s}) : $signed({2'b00, q_s});
            flip5_reg <= flip4_reg;
        end

        assign lane_z[l]    = z_reg;
        assign lane_flip[l] = flip5_reg;

        // Sine and cosine of the lane angle.
        if (l == 0) begin : g_lead
            gcd_cordic #(
                .ITERATIONS (CORDIC_ITERATIONS),
                .VECTORING  (1'b0),
                .TAG_W      (1)
            ) u_rot (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_valid  (conv_v_reg[4]),
                .in_x      ($signed({2'b00, GAIN_Q30})),
                .in_y      ('0),
                .in_z      (lane_z[l]),
                .in_tag    (lane_flip[l]),
                .out_valid (rot_valid),
                .out_x     (rot_x[l]),
                .out_y     (rot_y[l]),
                .out_z     (),
                .out_tag   (rot_tag[l])
            );
        end
        else begin : g_side
            gcd_cordic #(
                .ITERATIONS (CORDIC_ITERATIONS),
                .VECTORING  (1'b0),
                .TAG_W      (1)
            ) u_rot (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_valid  (conv_v_reg[4]),
                .in_x      ($signed({2'b00, GAIN_Q30})),
                .in_y      ('0),
                .in_z      (lane_z[l]),
                .in_tag    (lane_flip[l]),
                .out_valid (),
                .out_x     (rot_x[l]),
                .out_y     (rot_y[l]),
                .out_z     (),
                .out_tag   (rot_tag[l])
            );
        end
    end

    // Haversine term: products of the trig values.
    logic signed [CW-1:0]   ca;
    logic signed [CW-1:0]   cb;
    logic signed [2*CW-1:0] p_cc;
    logic signed [2*CW-1:0] p_sdl;
    logic signed [2*CW-1:0] p_sdo;
    logic signed [2*CW-1:0] p_m;
    logic signed [CW:0]     t_sum;
    logic signed [CW-1:0]   cc_reg;
    logic signed [CW-1:0]   sdl2_reg;
    logic signed [CW-1:0]   sdo2_reg;
    logic signed [CW-1:0]   m_reg;
    logic signed [CW-1:0]   sdl2b_reg;
    logic [30:0]            t_reg;
    logic [2:0]             term_v_reg;

    always_comb
    begin
        ca    = rot_tag[0][0] ? -rot_x[0] : rot_x[0];
        cb    = rot_tag[1][0] ? -rot_x[1] : rot_x[1];
        p_cc  = ca * cb;
        p_sdl = rot_y[2] * rot_y[2];
        p_sdo = rot_y[3] * rot_y[3];
        p_m   = cc_reg * sdo2_reg;
        t_sum = $signed({sdl2b_reg[CW-1], sdl2b_reg}) + $signed({m_reg[CW-1], m_reg});
    end

    always_ff @(posedge clk)
    begin
        cc_reg    <= CW'(p_cc >>> 30);
        sdl2_reg  <= CW'(p_sdl >>> 30);
        sdo2_reg  <= CW'(p_sdo >>> 30);
        m_reg     <= CW'(p_m >>> 30);
        sdl2b_reg <= sdl2_reg;
        // Clamp the term to 0..1.
        if (t_sum[CW])
        begin
            t_reg <= '0;
        end
        else if (t_sum > $signed({3'b000, ONE_Q30}))
        begin
            t_reg <= ONE_Q30[30:0];
        end
        else
        begin
            t_reg <= t_sum[30:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            term_v_reg <= '0;
        end
        else
        begin
            term_v_reg <= {term_v_reg[1:0], rot_valid};
        end
    end

    // Sine of the half angle: square root of the term.
    logic                 sq1_valid;
    logic [SQ_ROOT_W-1:0] sq1_root;

    gcd_isqrt #(
        .TAG_W (1)
    ) u_sqrt_sin (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (term_v_reg[2]),
        .in_rad    ({1'b0, t_reg, 30'd0}),
        .in_tag    (1'b0),
        .out_valid (sq1_valid),
        .out_root  (sq1_root),
        .out_tag   ()
    );

    // Cosine of the half angle: square root of one minus the sine squared.
    logic [SQ_ROOT_W-1:0] sq_reg;
    logic [SQ_ROOT_W-1:0] sqb_reg;
    logic [SQ_ROOT_W-1:0] sqc_reg;
    logic [SQ_RAD_W-1:0]  sqsq_reg;
    logic [SQ_RAD_W-1:0]  rad2_reg;
    logic [2:0]           cos_v_reg;

    always_ff @(posedge clk)
    begin
        sq_reg   <= (sq1_root > ONE_Q30[30:0]) ? ONE_Q30[30:0] : sq1_root;
        sqsq_reg <= SQ_RAD_W'(sq_reg * sq_reg);
        sqb_reg  <= sq_reg;
        rad2_reg <= (SQ_RAD_W'(1) << 60) - sqsq_reg;
        sqc_reg  <= sqb_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cos_v_reg <= '0;
        end
        else
        begin
            cos_v_reg <= {cos_v_reg[1:0], sq1_valid};
        end
    end

    logic                 sq2_valid;
    logic [SQ_ROOT_W-1:0] co_root;
    logic [SQ_ROOT_W-1:0] sin_tag;

    gcd_isqrt #(
        .TAG_W (SQ_ROOT_W)
    ) u_sqrt_cos (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cos_v_reg[2]),
        .in_rad    (rad2_reg),
        .in_tag    (sqc_reg),
        .out_valid (sq2_valid),
        .out_root  (co_root),
        .out_tag   (sin_tag)
    );

    // Half central angle as the angle of the vector (cos, sin).
    logic                 vec_valid;
    logic signed [CW-1:0] vec_z;

    gcd_cordic #(
        .ITERATIONS (CORDIC_ITERATIONS),
        .VECTORING  (1'b1),
        .TAG_W      (1)
    ) u_vec (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sq2_valid),
        .in_x      ($signed({3'b000, co_root})),
        .in_y      ($signed({3'b000, sin_tag})),
        .in_z      ('0),
        .in_tag    (1'b0),
        .out_valid (vec_valid),
        .out_x     (),
        .out_y     (),
        .out_z     (vec_z),
        .out_tag   ()
    );

    // Clamp to 0..pi/2 and scale by the radius.
    logic [30:0] zc_reg;
    logic        zc_v_reg;
    logic [55:0] dist_prod;

    assign dist_prod = radius_reg * {zc_reg, 1'b0};

    always_ff @(posedge clk)
    begin
        if (vec_z[CW-1])
        begin
            zc_reg <= '0;
        end
        else if (vec_z > $signed({2'b00, HALFPI_Q30}))
        begin
            zc_reg <= HALFPI_Q30[30:0];
        end
        else
        begin
            zc_reg <= vec_z[30:0];
        end
        distance_m <= dist_prod[55:30];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zc_v_reg <= 1'b0;
            done     <= 1'b0;
        end
        else
        begin
            zc_v_reg <= vec_valid;
            done     <= zc_v_reg;
        end
    end

endmodule

// ===== sv/gcd_isqrt.sv =====
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Digit-by-digit floor square root, one root bit per register stage, with a
// valid bit and a sideband tag travelling alongside.
// ----------------------------------------------------------------------------
module gcd_isqrt #(
    parameter int TAG_W = 1
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic [gcd_pkg::SQ_RAD_W-1:0]     in_rad,
    input  logic [TAG_W-1:0]                 in_tag,
    output logic                             out_valid,
    output logic [gcd_pkg::SQ_ROOT_W-1:0]    out_root,
    output logic [TAG_W-1:0]                 out_tag
);
    import gcd_pkg::*;

    localparam int STEPS = SQ_ROOT_W;
    localparam int REM_W = SQ_ROOT_W + 3;

    logic                 valid_reg [STEPS];
    logic [SQ_RAD_W-1:0]  rad_reg   [STEPS];
    logic [REM_W-1:0]     rem_reg   [STEPS];
    logic [SQ_ROOT_W-1:0] root_reg  [STEPS];
    logic [TAG_W-1:0]     tag_reg   [STEPS];

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        logic                 v_s;
        logic [SQ_RAD_W-1:0]  rad_s;
        logic [REM_W-1:0]     rem_s;
        logic [SQ_ROOT_W-1:0] root_s;
        logic [TAG_W-1:0]     tag_s;
        logic [REM_W-1:0]     rem_sh;
        logic [REM_W-1:0]     trial;
        logic                 ge;

        // Stage input: the ports for the first step, the previous step after.
        if (k == 0) begin : g_first
            assign v_s    = in_valid;
            assign rad_s  = in_rad;
            assign rem_s  = '0;
            assign root_s = '0;
            assign tag_s  = in_tag;
        end
        else begin : g_next
            assign v_s    = valid_reg[k-1];
            assign rad_s  = rad_reg[k-1];
            assign rem_s  = rem_reg[k-1];
            assign root_s = root_reg[k-1];
            assign tag_s  = tag_reg[k-1];
        end

        // Bring down two radicand bits and try the next root bit.
        always_comb
        begin
            rem_sh = {rem_s[REM_W-3:0], rad_s[SQ_RAD_W-1 -: 2]};
            trial  = {1'b0, root_s, 2'b01};
            ge     = (rem_sh >= trial);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else
            begin
                valid_reg[k] <= v_s;
            end
        end

        always_ff @(posedge clk)
        begin
            rad_reg[k]  <= {rad_s[SQ_RAD_W-3:0], 2'b00};
            rem_reg[k]  <= ge ? (rem_sh - trial) : rem_sh;
            root_reg[k] <= {root_s[SQ_ROOT_W-2:0], ge};
            tag_reg[k]  <= tag_s;
        end
    end

    assign out_valid = valid_reg[STEPS-1];
    assign out_root  = root_reg[STEPS-1];
    assign out_tag   = tag_reg[STEPS-1];

endmodule

// ===== sv/gcd_cordic.sv =====
// ----------------------------------------------------------------------------
// Pipelined CORDIC
// One micro-rotation per register stage, in rotation mode (drive z to zero)
// or vectoring mode (drive y to zero), with a valid bit and a sideband tag.
// ----------------------------------------------------------------------------
module gcd_cordic #(
    parameter int ITERATIONS = 24,
    parameter bit VECTORING  = 1'b0,
    parameter int TAG_W      = 1
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic signed [gcd_pkg::CW-1:0]    in_x,
    input  logic signed [gcd_pkg::CW-1:0]    in_y,
    input  logic signed [gcd_pkg::CW-1:0]    in_z,
    input  logic [TAG_W-1:0]                 in_tag,
    output logic                             out_valid,
    output logic signed [gcd_pkg::CW-1:0]    out_x,
    output logic signed [gcd_pkg::CW-1:0]    out_y,
    output logic signed [gcd_pkg::CW-1:0]    out_z,
    output logic [TAG_W-1:0]                 out_tag
);
    import gcd_pkg::*;

    logic                 valid_reg [ITERATIONS];
    logic signed [CW-1:0] x_reg     [ITERATIONS];
    logic signed [CW-1:0] y_reg     [ITERATIONS];
    logic signed [CW-1:0] z_reg     [ITERATIONS];
    logic [TAG_W-1:0]     tag_reg   [ITERATIONS];

    for (genvar i = 0; i < ITERATIONS; i++) begin : g_iter
        localparam logic signed [CW-1:0] ATAN = $signed({2'b00, atan_q30(i)});

        logic                 v_s;
        logic signed [CW-1:0] x_s;
        logic signed [CW-1:0] y_s;
        logic signed [CW-1:0] z_s;
        logic [TAG_W-1:0]     tag_s;
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;
        logic                 pos;

        if (i == 0) begin : g_first
            assign v_s   = in_valid;
            assign x_s   = in_x;
            assign y_s   = in_y;
            assign z_s   = in_z;
            assign tag_s = in_tag;
        end
        else begin : g_next
            assign v_s   = valid_reg[i-1];
            assign x_s   = x_reg[i-1];
            assign y_s   = y_reg[i-1];
            assign z_s   = z_reg[i-1];
            assign tag_s = tag_reg[i-1];
        end

        // Direction of this micro-rotation.
        always_comb
        begin
            dx = y_s >>> i;
            dy = x_s >>> i;
            if (VECTORING)
            begin
                pos = y_s[CW-1] || (y_s == '0);
            end
            else
            begin
                pos = !z_s[CW-1];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i] <= 1'b0;
            end
            else
            begin
                valid_reg[i] <= v_s;
            end
        end

        always_ff @(posedge clk)
        begin
            x_reg[i]   <= pos ? (x_s - dx) : (x_s + dx);
            y_reg[i]   <= pos ? (y_s + dy) : (y_s - dy);
            z_reg[i]   <= pos ? (z_s - ATAN) : (z_s + ATAN);
            tag_reg[i] <= tag_s;
        end
    end

    assign out_valid = valid_reg[ITERATIONS-1];
    assign out_x     = x_reg[ITERATIONS-1];
    assign out_y     = y_reg[ITERATIONS-1];
    assign out_z     = z_reg[ITERATIONS-1];
    assign out_tag   = tag_reg[ITERATIONS-1];

endmodule
